// ===== rtl/srot_pkg.sv =====
// Shared types and constants for the string rotation checker.
`timescale 1ns / 1ps
package srot_pkg;

	// Default store depth in characters
	localparam int unsigned MAX_LEN_DEF = 64;

	// Stream word widths
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 8;

	// Controller states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_START,
		ST_READ,
		ST_CMP,
		ST_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;        // accept the input word into the stores
		logic start_scan;  // clear the shift and position counters
		logic next_t;      // advance to the next character under this shift
		logic next_r;      // move on to the next shift
		logic set_verdict; // capture verdict_val
		logic verdict_val;
		logic push;        // write the result word and clear the lengths
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic ovf;       // overflow flag set for this pair
		logic len_eq;    // both lengths equal
		logic len_zero;  // first length is zero
		logic chars_eq;  // registered store reads match
		logic t_last;    // current character is the last one
		logic r_last;    // current shift is the last one
		logic out_busy;  // result register holds a word not yet taken
	} sts_t;

endpackage

// ===== rtl/srot_dp.sv =====
// Datapath of the string rotation checker: stores, lengths, scan counters and result register.
`timescale 1ns / 1ps
module srot_dp #(
	parameter int unsigned MAX_LEN = srot_pkg::MAX_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  srot_pkg::cmd_t                  cmd,
	output srot_pkg::sts_t                  sts,
	input  logic [srot_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [srot_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [srot_pkg::OUT_DATA_W-1:0] m_tdata
);
	import srot_pkg::*;

	localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int unsigned LW = $clog2(MAX_LEN + 1);
	localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);

	logic [7:0]    first_mem  [MAX_LEN];
	logic [7:0]    second_mem [MAX_LEN];
	logic [LW-1:0] first_len_q, second_len_q;
	logic          ovf_q;
	logic [LW-1:0] r_q, t_q, pos_q;
	logic [7:0]    first_rd_q, second_rd_q;
	logic          verdict_q;
	logic          out_valid_q;
	logic [1:0]    out_bits_q;
	logic [LW-1:0] r_inc, t_inc, pos_inc;
	logic          first_room, second_room;

	assign first_room  = first_len_q < LEN_MAX;
	assign second_room = second_len_q < LEN_MAX;
	assign r_inc   = r_q + LW'(1);
	assign t_inc   = t_q + LW'(1);
	assign pos_inc = pos_q + LW'(1);

	// Character stores, written while loading
	always_ff @(posedge clk) begin
		if (cmd.load && s_tuser[0] && first_room) begin
			first_mem[first_len_q[AW-1:0]] <= s_tdata[7:0];
		end
		if (cmd.load && s_tuser[1] && second_room) begin
			second_mem[second_len_q[AW-1:0]] <= s_tdata[15:8];
		end
	end

	// Registered reads at the current rotated position and character index
	always_ff @(posedge clk) begin
		first_rd_q  <= first_mem[pos_q[AW-1:0]];
		second_rd_q <= second_mem[t_q[AW-1:0]];
	end

	// Lengths and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q  <= '0;
			second_len_q <= '0;
			ovf_q        <= 1'b0;
		end else if (cmd.push) begin
			first_len_q  <= '0;
			second_len_q <= '0;
			ovf_q        <= 1'b0;
		end else if (cmd.load) begin
			if (s_tuser[0]) begin
				if (first_room) begin
					first_len_q <= first_len_q + LW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (s_tuser[1]) begin
				if (second_room) begin
					second_len_q <= second_len_q + LW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// Scan counters: shift, character index and wrapped position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q   <= '0;
			t_q   <= '0;
			pos_q <= '0;
		end else if (cmd.start_scan) begin
			r_q   <= '0;
			t_q   <= '0;
			pos_q <= '0;
		end else if (cmd.next_t) begin
			t_q   <= t_inc;
			pos_q <= (pos_inc == first_len_q) ? '0 : pos_inc;
		end else if (cmd.next_r) begin
			r_q   <= r_inc;
			t_q   <= '0;
			pos_q <= r_inc;
		end
	end

	// Verdict register
	always_ff @(posedge clk) begin
		if (cmd.set_verdict) begin
			verdict_q <= cmd.verdict_val;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_bits_q <= {ovf_q, verdict_q & ~ovf_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - 2){1'b0}}, out_bits_q};

	// Status to the controller
	always_comb begin
		sts.ovf      = ovf_q;
		sts.len_eq   = first_len_q == second_len_q;
		sts.len_zero = first_len_q == '0;
		sts.chars_eq = first_rd_q == second_rd_q;
		sts.t_last   = t_inc == first_len_q;
		sts.r_last   = r_inc == first_len_q;
		sts.out_busy = out_valid_q && !m_tready;
	end

endmodule

// ===== rtl/srot_ctrl.sv =====
// Controller state machine of the string rotation checker.
`timescale 1ns / 1ps
module srot_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  logic           s_tlast,
	output logic           s_tready,
	input  srot_pkg::sts_t sts,
	output srot_pkg::cmd_t cmd
);
	import srot_pkg::*;

	state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (s_tlast) begin
						state_nxt = ST_START;
					end
				end
			end
			ST_START: begin
				// Settle the trivial cases before any scan
				if (sts.ovf || !sts.len_eq) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict_val = 1'b0;
					state_nxt       = ST_DONE;
				end else if (sts.len_zero) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict_val = 1'b1;
					state_nxt       = ST_DONE;
				end else begin
					cmd.start_scan = 1'b1;
					state_nxt      = ST_READ;
				end
			end
			ST_READ: begin
				state_nxt = ST_CMP;
			end
			ST_CMP: begin
				if (sts.chars_eq) begin
					if (sts.t_last) begin
						cmd.set_verdict = 1'b1;
						cmd.verdict_val = 1'b1;
						state_nxt       = ST_DONE;
					end else begin
						cmd.next_t = 1'b1;
						state_nxt  = ST_READ;
					end
				end else if (sts.r_last) begin
					cmd.set_verdict = 1'b1;
					cmd.verdict_val = 1'b0;
					state_nxt       = ST_DONE;
				end else begin
					cmd.next_r = 1'b1;
					state_nxt  = ST_READ;
				end
			end
			ST_DONE: begin
				// Wait for the result register to free up
				if (!sts.out_busy) begin
					cmd.push  = 1'b1;
					state_nxt = ST_LOAD;
				end
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

endmodule

// ===== rtl/string_rotation_check_core.sv =====
// After the word marked last, ST_START settles the trivial cases; otherwise the scan tries each shift,
// with ST_READ reading one character pair through the registered read ports of the two stores
// and ST_CMP comparing it; the result then waits in ST_DONE until the result register is free.
// Throughput: one input word per cycle while loading; no input is taken during a scan.
// Reset clears the lengths, the overflow flag, the controller and the result valid;
// the character stores are not cleared.
`timescale 1ns / 1ps
module string_rotation_check_core #(
	parameter int unsigned MAX_LEN = srot_pkg::MAX_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [srot_pkg::IN_DATA_W-1:0]  s_tdata,  // first_char, second_char
	input  logic [srot_pkg::IN_USER_W-1:0]  s_tuser,  // first_valid, second_valid
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [srot_pkg::OUT_DATA_W-1:0] m_tdata   // is_rotation, overflow, zero fill
);
	import srot_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Controller
	srot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath
	srot_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

`ifndef NO_ASSERTIONS
	// A result word is never written over one still waiting
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !(m_tvalid && !m_tready))
		else $error("result pushed while output occupied");

	// An overflowed pair never reports a rotation
	a_ovf_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("rotation reported with overflow");

	// Lengths and overflow start from zero after each result
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> (sts.len_zero && sts.len_eq && !sts.ovf))
		else $error("pair state not cleared after result");

	// No input word is taken during a decision
	a_no_load_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input accepted during decision");
`endif

endmodule
